// ===== sv/segment_segment_distance_defines.svh =====
// ----------------------------------------------------------------------------
// Segment distance assertion macros
// Shared property shorthands for the checker of the segment distance block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_DISTANCE_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while reset is low.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is low.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment distance package
// Widths, register codes and shared types of the segment distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int CW       = 24;          // coordinate width
  localparam int DW       = CW + 1;      // coordinate difference
  localparam int PW       = 2 * DW;      // product of two differences
  localparam int SW       = PW + 2;      // dot product of three terms
  localparam int HW       = SW / 2;      // half of a dot product operand
  localparam int BW       = 2 * SW;      // product of two dot products
  localparam int NW       = BW + 2;      // determinant and numerators
  localparam int RW       = NW + 1;      // divider remainder
  localparam int QW       = 25;          // segment parameter, Q1.24
  localparam int TOL_FRAC = 24;
  localparam int LW       = QW + 1 + DW; // parameter times difference
  localparam int RNDW     = LW + 1;
  localparam int SHW      = RNDW - TOL_FRAC;
  localparam int VW       = SHW + 1;
  localparam int DSW      = 50;          // squared distance
  localparam int DMW      = 32;          // determinant threshold
  localparam int CIW      = 2;           // register index

  localparam logic [CIW-1:0] CFG_PARAM_LOW  = CIW'(0);
  localparam logic [CIW-1:0] CFG_PARAM_HIGH = CIW'(1);
  localparam logic [CIW-1:0] CFG_DET_MIN    = CIW'(2);

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0] p0;
    coord_t [2:0] p1;
    coord_t [2:0] q0;
    coord_t [2:0] q1;
  } pts_t;

  typedef struct packed {
    logic signed [SW-1:0] aa;
    logic signed [SW-1:0] ab;
    logic signed [SW-1:0] bb;
    logic signed [SW-1:0] ra;
    logic signed [SW-1:0] rb;
  } dot_t;

  typedef struct packed {
    pts_t pts;
    logic rej_s;
    logic rej_t;
  } side_t;

  function automatic logic signed [DW-1:0] diff(input coord_t x, input coord_t y);
    return {x[CW-1], x} - {y[CW-1], y};
  endfunction

endpackage

// ===== sv/ssd_front.sv =====
// ----------------------------------------------------------------------------
// Segment distance front end
// Three stages: endpoint differences, their products, and the five dot sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  ssd_pkg::pts_t in_pts,
  input  logic          dn_ready,
  output logic          up_ready,
  output logic          out_valid,
  output ssd_pkg::pts_t out_pts,
  output ssd_pkg::dot_t out_dot
);

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   rdy;

  logic signed [ssd_pkg::DW-1:0] r1_r [3];
  logic signed [ssd_pkg::DW-1:0] a1_r [3];
  logic signed [ssd_pkg::DW-1:0] b1_r [3];
  ssd_pkg::pts_t                 pts1_r;

  logic signed [ssd_pkg::PW-1:0] aa2_r [3];
  logic signed [ssd_pkg::PW-1:0] ab2_r [3];
  logic signed [ssd_pkg::PW-1:0] bb2_r [3];
  logic signed [ssd_pkg::PW-1:0] ra2_r [3];
  logic signed [ssd_pkg::PW-1:0] rb2_r [3];
  ssd_pkg::pts_t                 pts2_r;

  ssd_pkg::dot_t dot3_r;
  ssd_pkg::pts_t pts3_r;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt    = {v_r[NS-2:0], in_valid};
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        r1_r[i] <= ssd_pkg::diff(in_pts.p0[i], in_pts.q0[i]);
        a1_r[i] <= ssd_pkg::diff(in_pts.p1[i], in_pts.p0[i]);
        b1_r[i] <= ssd_pkg::diff(in_pts.q0[i], in_pts.q1[i]);
      end
      pts1_r <= in_pts;
    end
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        aa2_r[i] <= a1_r[i] * a1_r[i];
        ab2_r[i] <= a1_r[i] * b1_r[i];
        bb2_r[i] <= b1_r[i] * b1_r[i];
        ra2_r[i] <= r1_r[i] * a1_r[i];
        rb2_r[i] <= r1_r[i] * b1_r[i];
      end
      pts2_r <= pts1_r;
    end
    if (rdy[2]) begin
      dot3_r.aa <= ssd_pkg::SW'(aa2_r[0]) + ssd_pkg::SW'(aa2_r[1]) + ssd_pkg::SW'(aa2_r[2]);
      dot3_r.ab <= ssd_pkg::SW'(ab2_r[0]) + ssd_pkg::SW'(ab2_r[1]) + ssd_pkg::SW'(ab2_r[2]);
      dot3_r.bb <= ssd_pkg::SW'(bb2_r[0]) + ssd_pkg::SW'(bb2_r[1]) + ssd_pkg::SW'(bb2_r[2]);
      dot3_r.ra <= ssd_pkg::SW'(ra2_r[0]) + ssd_pkg::SW'(ra2_r[1]) + ssd_pkg::SW'(ra2_r[2]);
      dot3_r.rb <= ssd_pkg::SW'(rb2_r[0]) + ssd_pkg::SW'(rb2_r[1]) + ssd_pkg::SW'(rb2_r[2]);
      pts3_r    <= pts2_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_pts   = pts3_r;
  assign out_dot   = dot3_r;

endmodule

// ===== sv/ssd_solve.sv =====
// ----------------------------------------------------------------------------
// Segment distance normal-equation solver front
// Forms the determinant and the two numerators with split multipliers, then
// applies the determinant threshold and the range screens before division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_solve (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  ssd_pkg::pts_t                in_pts,
  input  ssd_pkg::dot_t                in_dot,
  input  logic [ssd_pkg::DMW-1:0]      det_min,
  input  logic                         dn_ready,
  output logic                         up_ready,
  output logic                         out_valid,
  output logic [1:0][ssd_pkg::RW-1:0]  out_num,
  output logic [ssd_pkg::RW-1:0]       out_den,
  output ssd_pkg::side_t               out_side
);

  localparam int NS = 4;
  localparam int NP = 6;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   rdy;

  logic signed [ssd_pkg::SW-1:0] opx [NP];
  logic signed [ssd_pkg::SW-1:0] opy [NP];

  logic signed [2*ssd_pkg::HW-1:0] hh_nxt [NP];
  logic signed [2*ssd_pkg::HW:0]   hl_nxt [NP];
  logic signed [2*ssd_pkg::HW:0]   lh_nxt [NP];
  logic        [2*ssd_pkg::HW-1:0] ll_nxt [NP];

  logic signed [2*ssd_pkg::HW-1:0] hh_r [NP];
  logic signed [2*ssd_pkg::HW:0]   hl_r [NP];
  logic signed [2*ssd_pkg::HW:0]   lh_r [NP];
  logic        [2*ssd_pkg::HW-1:0] ll_r [NP];
  ssd_pkg::pts_t                   pts1_r;

  logic signed [ssd_pkg::BW-1:0] prod_r [NP];
  ssd_pkg::pts_t                 pts2_r;

  logic signed [ssd_pkg::NW-1:0] det_r;
  logic signed [ssd_pkg::NW-1:0] ns_r;
  logic signed [ssd_pkg::NW-1:0] nt_r;
  ssd_pkg::pts_t                 pts3_r;

  logic                          det_small;
  logic signed [ssd_pkg::NW-1:0] den_m;
  logic signed [ssd_pkg::NW-1:0] ns_m;
  logic signed [ssd_pkg::NW-1:0] nt_m;
  logic [ssd_pkg::RW-1:0]        den_x2;

  logic [1:0][ssd_pkg::RW-1:0] num4_r;
  logic [ssd_pkg::RW-1:0]      den4_r;
  ssd_pkg::side_t              side4_r;

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt    = {v_r[NS-2:0], in_valid};
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  // Operand pairs: aa*bb, ab*ab, ab*rb, bb*ra, ab*ra, aa*rb.
  always_comb begin
    opx[0] = in_dot.aa; opy[0] = in_dot.bb;
    opx[1] = in_dot.ab; opy[1] = in_dot.ab;
    opx[2] = in_dot.ab; opy[2] = in_dot.rb;
    opx[3] = in_dot.bb; opy[3] = in_dot.ra;
    opx[4] = in_dot.ab; opy[4] = in_dot.ra;
    opx[5] = in_dot.aa; opy[5] = in_dot.rb;
  end

  // Each wide product is split into a signed upper half and an unsigned
  // lower half, giving four partial products of half width.
  always_comb begin
    for (int j = 0; j < NP; j++) begin
      hh_nxt[j] = $signed(opx[j][ssd_pkg::SW-1:ssd_pkg::HW])
                * $signed(opy[j][ssd_pkg::SW-1:ssd_pkg::HW]);
      hl_nxt[j] = $signed(opx[j][ssd_pkg::SW-1:ssd_pkg::HW])
                * $signed({1'b0, opy[j][ssd_pkg::HW-1:0]});
      lh_nxt[j] = $signed({1'b0, opx[j][ssd_pkg::HW-1:0]})
                * $signed(opy[j][ssd_pkg::SW-1:ssd_pkg::HW]);
      ll_nxt[j] = opx[j][ssd_pkg::HW-1:0] * opy[j][ssd_pkg::HW-1:0];
    end
  end

  always_comb begin
    det_small = det_r <= $signed(ssd_pkg::NW'(det_min));
    den_m     = det_small ? ssd_pkg::NW'(1) : det_r;
    ns_m      = det_small ? '0 : ns_r;
    nt_m      = det_small ? '0 : nt_r;
    den_x2    = {den_m, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < NP; j++) begin
        hh_r[j] <= hh_nxt[j];
        hl_r[j] <= hl_nxt[j];
        lh_r[j] <= lh_nxt[j];
        ll_r[j] <= ll_nxt[j];
      end
      pts1_r <= in_pts;
    end
    if (rdy[1]) begin
      for (int j = 0; j < NP; j++) begin
        prod_r[j] <= (ssd_pkg::BW'(hh_r[j]) << (2 * ssd_pkg::HW))
                   + ((ssd_pkg::BW'(hl_r[j]) + ssd_pkg::BW'(lh_r[j])) << ssd_pkg::HW)
                   + ssd_pkg::BW'(ll_r[j]);
      end
      pts2_r <= pts1_r;
    end
    if (rdy[2]) begin
      det_r  <= ssd_pkg::NW'(prod_r[0]) - ssd_pkg::NW'(prod_r[1]);
      ns_r   <= ssd_pkg::NW'(prod_r[2]) - ssd_pkg::NW'(prod_r[3]);
      nt_r   <= ssd_pkg::NW'(prod_r[4]) - ssd_pkg::NW'(prod_r[5]);
      pts3_r <= pts2_r;
    end
    if (rdy[3]) begin
      num4_r[0]     <= ssd_pkg::RW'(ns_m);
      num4_r[1]     <= ssd_pkg::RW'(nt_m);
      den4_r        <= ssd_pkg::RW'(den_m);
      // A negative numerator, or one of at least twice the determinant,
      // puts the parameter outside any tolerance the registers can hold.
      side4_r.rej_s <= ns_m[ssd_pkg::NW-1] || (ssd_pkg::RW'(ns_m) >= den_x2);
      side4_r.rej_t <= nt_m[ssd_pkg::NW-1] || (ssd_pkg::RW'(nt_m) >= den_x2);
      side4_r.pts   <= pts3_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_num   = num4_r;
  assign out_den   = den4_r;
  assign out_side  = side4_r;

endmodule

// ===== sv/ssd_div.sv =====
// ----------------------------------------------------------------------------
// Segment distance parameter divider
// Restoring division of both numerators by the determinant, one quotient bit
// per stage, giving s and t in Q1.24 plus a nonzero-remainder flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [1:0][ssd_pkg::RW-1:0] in_num,
  input  logic [ssd_pkg::RW-1:0]      in_den,
  input  ssd_pkg::side_t              in_side,
  input  logic                        dn_ready,
  output logic                        up_ready,
  output logic                        out_valid,
  output logic [1:0][ssd_pkg::QW-1:0] out_quo,
  output logic [1:0]                  out_rem_nz,
  output ssd_pkg::side_t              out_side
);

  localparam int NS = ssd_pkg::QW;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   rdy;

  logic [1:0][ssd_pkg::RW-1:0] rem_r  [NS];
  logic [1:0][ssd_pkg::QW-1:0] quo_r  [NS];
  logic [ssd_pkg::RW-1:0]      den_r  [NS];
  ssd_pkg::side_t              side_r [NS];

  logic [1:0][ssd_pkg::RW-1:0] rem_nxt [NS];
  logic [1:0][ssd_pkg::QW-1:0] quo_nxt [NS];

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt    = {v_r[NS-2:0], in_valid};
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  // The first stage settles the integer bit; every later stage doubles the
  // partial remainder and tries one subtraction of the determinant.
  always_comb begin
    logic [ssd_pkg::RW-1:0] rin;
    logic [ssd_pkg::RW-1:0] dk;
    logic [ssd_pkg::QW-1:0] qin;
    logic                   ge;
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rin = in_num[l];
          dk  = in_den;
          qin = '0;
        end else begin
          rin = {rem_r[k-1][l][ssd_pkg::RW-2:0], 1'b0};
          dk  = den_r[k-1];
          qin = quo_r[k-1][l];
        end
        ge            = rin >= dk;
        rem_nxt[k][l] = ge ? rin - dk : rin;
        quo_nxt[k][l] = {qin[ssd_pkg::QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= (k == 0) ? in_den : den_r[(k == 0) ? 0 : k - 1];
        side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_quo       = quo_r[NS-1];
  assign out_rem_nz[0] = |rem_r[NS-1][0];
  assign out_rem_nz[1] = |rem_r[NS-1][1];
  assign out_side      = side_r[NS-1];

endmodule

// ===== sv/ssd_point.sv =====
// ----------------------------------------------------------------------------
// Segment distance point stage
// Tolerance test, closest points by interpolation with saturation, and the
// squared distance, ending in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_point (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [1:0][ssd_pkg::QW-1:0] in_quo,
  input  logic [1:0]                  in_rem_nz,
  input  ssd_pkg::side_t              in_side,
  input  logic [ssd_pkg::QW-1:0]      param_low,
  input  logic [ssd_pkg::QW-1:0]      param_high,
  input  logic                        dn_ready,
  output logic                        up_ready,
  output logic                        out_valid,
  output logic                        out_interior,
  output logic [ssd_pkg::DSW-1:0]     out_dist_sq,
  output ssd_pkg::coord_t [2:0]       out_near_a,
  output ssd_pkg::coord_t [2:0]       out_near_b
);

  localparam int NS = 5;

  function automatic ssd_pkg::coord_t sat(input logic signed [ssd_pkg::VW-1:0] v);
    logic [ssd_pkg::VW-ssd_pkg::CW:0] top;
    top = v[ssd_pkg::VW-1:ssd_pkg::CW-1];
    if (&top || ~|top) return v[ssd_pkg::CW-1:0];
    if (v[ssd_pkg::VW-1]) return {1'b1, {(ssd_pkg::CW-1){1'b0}}};
    return {1'b0, {(ssd_pkg::CW-1){1'b1}}};
  endfunction

  function automatic logic in_tol(input logic [ssd_pkg::QW-1:0] q, input logic nz,
                                  input logic [ssd_pkg::QW-1:0] lo,
                                  input logic [ssd_pkg::QW-1:0] hi);
    return (q >= lo) && (q < hi || (q == hi && !nz));
  endfunction

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   rdy;
  logic [NS-2:0] keep_r;

  logic [ssd_pkg::QW-1:0]        qs1_r;
  logic [ssd_pkg::QW-1:0]        qt1_r;
  logic signed [ssd_pkg::DW-1:0] ea1_r [3];
  logic signed [ssd_pkg::DW-1:0] eb1_r [3];
  ssd_pkg::coord_t               pa1_r [3];
  ssd_pkg::coord_t               pb1_r [3];

  logic signed [ssd_pkg::LW-1:0] ma2_r [3];
  logic signed [ssd_pkg::LW-1:0] mb2_r [3];
  ssd_pkg::coord_t               pa2_r [3];
  ssd_pkg::coord_t               pb2_r [3];

  ssd_pkg::coord_t na3_r [3];
  ssd_pkg::coord_t nb3_r [3];
  ssd_pkg::coord_t na_nxt [3];
  ssd_pkg::coord_t nb_nxt [3];

  logic [ssd_pkg::PW-1:0] sq4_r [3];
  ssd_pkg::coord_t        na4_r [3];
  ssd_pkg::coord_t        nb4_r [3];

  logic                      int5_r;
  logic [ssd_pkg::DSW-1:0]   dist5_r;
  ssd_pkg::coord_t [2:0]     na5_r;
  ssd_pkg::coord_t [2:0]     nb5_r;
  logic [ssd_pkg::DSW+1:0]   dist_sum;

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt    = {v_r[NS-2:0], in_valid};
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  // Rounded half up: add half an integer LSB at the Q1.24 fraction scale, then floor.
  always_comb begin
    logic signed [ssd_pkg::RNDW-1:0] ra;
    logic signed [ssd_pkg::RNDW-1:0] rb;
    for (int i = 0; i < 3; i++) begin
      ra = ssd_pkg::RNDW'(ma2_r[i]) + ssd_pkg::RNDW'(1 << (ssd_pkg::TOL_FRAC - 1));
      rb = ssd_pkg::RNDW'(mb2_r[i]) + ssd_pkg::RNDW'(1 << (ssd_pkg::TOL_FRAC - 1));
      na_nxt[i] = sat(ssd_pkg::VW'($signed(ra[ssd_pkg::RNDW-1:ssd_pkg::TOL_FRAC]))
                    + ssd_pkg::VW'(pa2_r[i]));
      nb_nxt[i] = sat(ssd_pkg::VW'($signed(rb[ssd_pkg::RNDW-1:ssd_pkg::TOL_FRAC]))
                    + ssd_pkg::VW'(pb2_r[i]));
    end
  end

  assign dist_sum = ssd_pkg::DSW'(sq4_r[0]) + (ssd_pkg::DSW+2)'(sq4_r[1])
                  + (ssd_pkg::DSW+2)'(sq4_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      keep_r[0] <= !in_side.rej_s && !in_side.rej_t
                && in_tol(in_quo[0], in_rem_nz[0], param_low, param_high)
                && in_tol(in_quo[1], in_rem_nz[1], param_low, param_high);
      qs1_r <= in_quo[0];
      qt1_r <= in_quo[1];
      for (int i = 0; i < 3; i++) begin
        ea1_r[i] <= ssd_pkg::diff(in_side.pts.p1[i], in_side.pts.p0[i]);
        eb1_r[i] <= ssd_pkg::diff(in_side.pts.q1[i], in_side.pts.q0[i]);
        pa1_r[i] <= in_side.pts.p0[i];
        pb1_r[i] <= in_side.pts.q0[i];
      end
    end
    if (rdy[1]) begin
      keep_r[1] <= keep_r[0];
      for (int i = 0; i < 3; i++) begin
        ma2_r[i] <= $signed({1'b0, qs1_r}) * ea1_r[i];
        mb2_r[i] <= $signed({1'b0, qt1_r}) * eb1_r[i];
        pa2_r[i] <= pa1_r[i];
        pb2_r[i] <= pb1_r[i];
      end
    end
    if (rdy[2]) begin
      keep_r[2] <= keep_r[1];
      for (int i = 0; i < 3; i++) begin
        na3_r[i] <= na_nxt[i];
        nb3_r[i] <= nb_nxt[i];
      end
    end
    if (rdy[3]) begin
      keep_r[3] <= keep_r[2];
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= $unsigned(ssd_pkg::PW'(ssd_pkg::diff(na3_r[i], nb3_r[i]))
                            * ssd_pkg::PW'(ssd_pkg::diff(na3_r[i], nb3_r[i])));
        na4_r[i] <= na3_r[i];
        nb4_r[i] <= nb3_r[i];
      end
    end
    if (rdy[4]) begin
      // Three squares of at most 2^48 each cannot reach the 50-bit ceiling.
      int5_r    <= keep_r[3];
      dist5_r   <= keep_r[3] ? dist_sum[ssd_pkg::DSW-1:0] : '0;
      for (int i = 0; i < 3; i++) begin
        na5_r[i] <= keep_r[3] ? na4_r[i] : '0;
        nb5_r[i] <= keep_r[3] ? nb4_r[i] : '0;
      end
    end
  end

  assign out_valid    = v_r[NS-1];
  assign out_interior = int5_r;
  assign out_dist_sq  = dist5_r;
  assign out_near_a   = na5_r;
  assign out_near_b   = nb5_r;

endmodule

// ===== sv/segment_segment_distance.sv =====
// ----------------------------------------------------------------------------
// Segment to segment distance
// Closest points between two 3D segments and their squared distance.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock while not stalled and returns
// one result per pair, in order, through 3 stages of dot products, 4 stages
// of determinant and numerator arithmetic, 25 stages of restoring division
// (one quotient bit of s and t per stage), and 5 stages of interpolation
// and distance. Stalls propagate stage by stage, so empty stages keep
// filling while a result waits. Register writes take effect at once and
// must only be made while no pair is in flight.
`timescale 1ns / 1ps

module segment_segment_distance (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssd_pkg::CIW-1:0]       cfg_index,
  input  logic [ssd_pkg::DMW-1:0]       cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [ssd_pkg::CW-1:0] in_a_start_x,
  input  logic signed [ssd_pkg::CW-1:0] in_a_start_y,
  input  logic signed [ssd_pkg::CW-1:0] in_a_start_z,
  input  logic signed [ssd_pkg::CW-1:0] in_a_end_x,
  input  logic signed [ssd_pkg::CW-1:0] in_a_end_y,
  input  logic signed [ssd_pkg::CW-1:0] in_a_end_z,
  input  logic signed [ssd_pkg::CW-1:0] in_b_start_x,
  input  logic signed [ssd_pkg::CW-1:0] in_b_start_y,
  input  logic signed [ssd_pkg::CW-1:0] in_b_start_z,
  input  logic signed [ssd_pkg::CW-1:0] in_b_end_x,
  input  logic signed [ssd_pkg::CW-1:0] in_b_end_y,
  input  logic signed [ssd_pkg::CW-1:0] in_b_end_z,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_interior,
  output logic [ssd_pkg::DSW-1:0]       out_dist_sq,
  output logic signed [ssd_pkg::CW-1:0] out_near_a_x,
  output logic signed [ssd_pkg::CW-1:0] out_near_a_y,
  output logic signed [ssd_pkg::CW-1:0] out_near_a_z,
  output logic signed [ssd_pkg::CW-1:0] out_near_b_x,
  output logic signed [ssd_pkg::CW-1:0] out_near_b_y,
  output logic signed [ssd_pkg::CW-1:0] out_near_b_z
);

  logic [ssd_pkg::QW-1:0]  param_low_r;
  logic [ssd_pkg::QW-1:0]  param_high_r;
  logic [ssd_pkg::DMW-1:0] det_min_r;

  ssd_pkg::pts_t in_pts;

  logic          fr_valid, fr_ready_up;
  ssd_pkg::pts_t fr_pts;
  ssd_pkg::dot_t fr_dot;

  logic                        sv_valid, sv_ready_up;
  logic [1:0][ssd_pkg::RW-1:0] sv_num;
  logic [ssd_pkg::RW-1:0]      sv_den;
  ssd_pkg::side_t              sv_side;

  logic                        dv_valid, dv_ready_up;
  logic [1:0][ssd_pkg::QW-1:0] dv_quo;
  logic [1:0]                  dv_rem_nz;
  ssd_pkg::side_t              dv_side;

  logic                  pt_ready_up;
  ssd_pkg::coord_t [2:0] near_a;
  ssd_pkg::coord_t [2:0] near_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_low_r  <= ssd_pkg::QW'(17);
      param_high_r <= ssd_pkg::QW'(16777199);
      det_min_r    <= ssd_pkg::DMW'(281);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssd_pkg::CFG_PARAM_LOW:  param_low_r  <= cfg_data[ssd_pkg::QW-1:0];
        ssd_pkg::CFG_PARAM_HIGH: param_high_r <= cfg_data[ssd_pkg::QW-1:0];
        ssd_pkg::CFG_DET_MIN:    det_min_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_pts.p0[0] = in_a_start_x; in_pts.p0[1] = in_a_start_y; in_pts.p0[2] = in_a_start_z;
    in_pts.p1[0] = in_a_end_x;   in_pts.p1[1] = in_a_end_y;   in_pts.p1[2] = in_a_end_z;
    in_pts.q0[0] = in_b_start_x; in_pts.q0[1] = in_b_start_y; in_pts.q0[2] = in_b_start_z;
    in_pts.q1[0] = in_b_end_x;   in_pts.q1[1] = in_b_end_y;   in_pts.q1[2] = in_b_end_z;
  end

  assign in_stall = !fr_ready_up;

  ssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_pts    (in_pts),
    .dn_ready  (sv_ready_up),
    .up_ready  (fr_ready_up),
    .out_valid (fr_valid),
    .out_pts   (fr_pts),
    .out_dot   (fr_dot)
  );

  ssd_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_pts    (fr_pts),
    .in_dot    (fr_dot),
    .det_min   (det_min_r),
    .dn_ready  (dv_ready_up),
    .up_ready  (sv_ready_up),
    .out_valid (sv_valid),
    .out_num   (sv_num),
    .out_den   (sv_den),
    .out_side  (sv_side)
  );

  ssd_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sv_valid),
    .in_num     (sv_num),
    .in_den     (sv_den),
    .in_side    (sv_side),
    .dn_ready   (pt_ready_up),
    .up_ready   (dv_ready_up),
    .out_valid  (dv_valid),
    .out_quo    (dv_quo),
    .out_rem_nz (dv_rem_nz),
    .out_side   (dv_side)
  );

  ssd_point u_point (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (dv_valid),
    .in_quo       (dv_quo),
    .in_rem_nz    (dv_rem_nz),
    .in_side      (dv_side),
    .param_low    (param_low_r),
    .param_high   (param_high_r),
    .dn_ready     (!out_stall),
    .up_ready     (pt_ready_up),
    .out_valid    (out_valid),
    .out_interior (out_interior),
    .out_dist_sq  (out_dist_sq),
    .out_near_a   (near_a),
    .out_near_b   (near_b)
  );

  assign out_near_a_x = near_a[0];
  assign out_near_a_y = near_a[1];
  assign out_near_a_z = near_a[2];
  assign out_near_b_x = near_b[0];
  assign out_near_b_y = near_b[1];
  assign out_near_b_z = near_b[2];

endmodule

// ===== sv/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// Segment distance port checker
// Watches the top-level ports for stall, result and input back-pressure rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_segment_distance_defines.svh"

module ssd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_interior,
  input logic [ssd_pkg::DSW-1:0]       out_dist_sq,
  input logic signed [ssd_pkg::CW-1:0] out_near_a_x,
  input logic signed [ssd_pkg::CW-1:0] out_near_a_y,
  input logic signed [ssd_pkg::CW-1:0] out_near_a_z,
  input logic signed [ssd_pkg::CW-1:0] out_near_b_x,
  input logic signed [ssd_pkg::CW-1:0] out_near_b_y,
  input logic signed [ssd_pkg::CW-1:0] out_near_b_z
);

  // A rejected pair carries an all-zero result.
  `SSD_ASSERT_NOW(a_reject_zero, out_valid && !out_interior, out_dist_sq == '0 && out_near_a_x == '0 && out_near_a_y == '0 && out_near_a_z == '0 && out_near_b_x == '0 && out_near_b_y == '0 && out_near_b_z == '0, "rejected result is not zero")

  // The input is held off only when the whole pipe is full and blocked.
  `SSD_ASSERT_NOW(a_stall_full, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

  // A result waiting under stall stays put for the next cycle.
  `SSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_dist_sq) && $stable(out_interior) && $stable(out_near_a_x) && $stable(out_near_b_x), "stalled result changed")

endmodule

bind segment_segment_distance ssd_checker u_ssd_checker (.*);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Segment to segment distance testbench
// Drives segment pairs with random gaps and output stalls, predicts each result
// with exact wide integer arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  typedef logic signed [255:0] big_t;

  typedef struct {
    coord_t c[12];
  } pair_t;

  typedef struct {
    logic           interior;
    logic [DSW-1:0] dist_sq;
    coord_t         na[3];
    coord_t         nb[3];
  } closest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [CIW-1:0] cfg_index = CFG_PARAM_LOW;
  logic [DMW-1:0] cfg_data = '0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_c[12];

  logic           out_valid;
  logic           out_stall = 1'b0;
  logic           out_interior;
  logic [DSW-1:0] out_dist_sq;
  coord_t         out_na[3];
  coord_t         out_nb[3];

  logic [24:0] tol_low = 25'd17;
  logic [24:0] tol_high = 25'd16777199;
  logic [31:0] det_thresh = 32'd281;

  pair_t    pending_pairs[$];
  closest_t expected_results[$];
  pair_t    cur_pair;
  bit       in_taken = 1'b0;
  int       in_gap = 0;
  int       stall_left = 0;
  bit       no_idle = 1'b0;
  int       errors = 0;

  initial for (int i = 0; i < 12; i++) in_c[i] = '0;

  always #10 clk = ~clk;

  segment_segment_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(in_c[0]), .in_a_start_y(in_c[1]), .in_a_start_z(in_c[2]),
    .in_a_end_x(in_c[3]), .in_a_end_y(in_c[4]), .in_a_end_z(in_c[5]),
    .in_b_start_x(in_c[6]), .in_b_start_y(in_c[7]), .in_b_start_z(in_c[8]),
    .in_b_end_x(in_c[9]), .in_b_end_y(in_c[10]), .in_b_end_z(in_c[11]),
    .out_valid(out_valid), .out_stall(out_stall), .out_interior(out_interior),
    .out_dist_sq(out_dist_sq),
    .out_near_a_x(out_na[0]), .out_near_a_y(out_na[1]), .out_near_a_z(out_na[2]),
    .out_near_b_x(out_nb[0]), .out_near_b_y(out_nb[1]), .out_near_b_z(out_nb[2])
  );

  function automatic coord_t interpolate(big_t p, big_t e, big_t q);
    big_t v;
    v = p + ((q * (e - p) + (big_t'(1) <<< 23)) >>> 24);
    if (v > big_t'(8388607)) v = big_t'(8388607);
    if (v < -big_t'(8388608)) v = -big_t'(8388608);
    return coord_t'(v);
  endfunction

  function automatic closest_t closest_points(pair_t pr);
    closest_t res;
    big_t p0[3], p1[3], q0[3], q1[3];
    big_t aa, ab, bb, ra, rb, det, ns, nt, den, lo, hi, xs, xt, qs, qt, d, dsum;
    big_t dmax;
    aa = '0; ab = '0; bb = '0; ra = '0; rb = '0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = big_t'(pr.c[i]); p1[i] = big_t'(pr.c[3+i]);
      q0[i] = big_t'(pr.c[6+i]); q1[i] = big_t'(pr.c[9+i]);
      aa += (p1[i] - p0[i]) * (p1[i] - p0[i]);
      ab += (p1[i] - p0[i]) * (q0[i] - q1[i]);
      bb += (q0[i] - q1[i]) * (q0[i] - q1[i]);
      ra += (p0[i] - q0[i]) * (p1[i] - p0[i]);
      rb += (p0[i] - q0[i]) * (q0[i] - q1[i]);
    end
    det = aa * bb - ab * ab;
    ns = ab * rb - bb * ra;
    nt = ab * ra - aa * rb;
    den = det;
    if (det <= big_t'({224'b0, det_thresh})) begin
      ns = '0; nt = '0; den = big_t'(1);
    end
    lo = big_t'({231'b0, tol_low});
    hi = big_t'({231'b0, tol_high});
    xs = ns <<< 24;
    xt = nt <<< 24;
    res.interior = 1'b0;
    res.dist_sq = '0;
    for (int i = 0; i < 3; i++) begin
      res.na[i] = '0; res.nb[i] = '0;
    end
    if (xs < lo * den || xs > hi * den || xt < lo * den || xt > hi * den) return res;
    // Both numerators are non-negative here, so division is a floor.
    qs = xs / den;
    qt = xt / den;
    dsum = '0;
    dmax = (big_t'(1) <<< 50) - 1;
    for (int i = 0; i < 3; i++) begin
      res.na[i] = interpolate(p0[i], p1[i], qs);
      res.nb[i] = interpolate(q0[i], q1[i], qt);
      d = big_t'(res.na[i]) - big_t'(res.nb[i]);
      dsum += d * d;
      if (dsum > dmax) dsum = dmax;
    end
    res.interior = 1'b1;
    res.dist_sq = dsum[DSW-1:0];
    return res;
  endfunction

  // Input driver: a pair stays on the port until its transfer.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        cur_pair = pending_pairs.pop_front();
        for (int i = 0; i < 12; i++) in_c[i] <= cur_pair.c[i];
        in_valid <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    closest_t want;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(closest_points(cur_pair));
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_interior !== want.interior) begin
          $display("%0t: interior expected %0b actual %0b", $time, want.interior, out_interior);
          errors++;
        end
        if (out_dist_sq !== want.dist_sq) begin
          $display("%0t: dist_sq expected %0d actual %0d", $time, want.dist_sq, out_dist_sq);
          errors++;
        end
        for (int i = 0; i < 3; i++) begin
          if (out_na[i] !== want.na[i]) begin
            $display("%0t: near_a[%0d] expected %0d actual %0d", $time, i, want.na[i], out_na[i]);
            errors++;
          end
          if (out_nb[i] !== want.nb[i]) begin
            $display("%0t: near_b[%0d] expected %0d actual %0d", $time, i, want.nb[i], out_nb[i]);
            errors++;
          end
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
    end
  end

  function automatic coord_t rand_coord(int span);
    if (span >= 24) return coord_t'($urandom);
    return coord_t'($urandom_range(0, (1 << (span + 1)) - 1) - (1 << span));
  endfunction

  // Mostly crossing pairs, so that both parameters tend to land inside.
  function automatic pair_t random_pair();
    pair_t pr;
    int kind, span;
    coord_t ctr, u, v, w;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 21 : $urandom_range(8, 18);
    if (kind < 2) begin
      for (int i = 0; i < 12; i++) pr.c[i] = rand_coord(24);
    end else if (kind < 4) begin
      for (int i = 0; i < 12; i++) pr.c[i] = rand_coord(span);
    end else begin
      for (int i = 0; i < 3; i++) begin
        ctr = rand_coord(span);
        u = rand_coord(span);
        v = rand_coord(span);
        w = rand_coord(span - 3);
        pr.c[i] = ctr - u;
        pr.c[3+i] = ctr + u;
        pr.c[6+i] = ctr + w - v;
        pr.c[9+i] = ctr + w + v;
      end
    end
    return pr;
  endfunction

  function automatic pair_t make_pair(int ax0, int ay0, int az0, int ax1, int ay1, int az1,
                                      int bx0, int by0, int bz0, int bx1, int by1, int bz1);
    pair_t pr;
    pr.c[0] = coord_t'(ax0); pr.c[1] = coord_t'(ay0); pr.c[2] = coord_t'(az0);
    pr.c[3] = coord_t'(ax1); pr.c[4] = coord_t'(ay1); pr.c[5] = coord_t'(az1);
    pr.c[6] = coord_t'(bx0); pr.c[7] = coord_t'(by0); pr.c[8] = coord_t'(bz0);
    pr.c[9] = coord_t'(bx1); pr.c[10] = coord_t'(by1); pr.c[11] = coord_t'(bz1);
    return pr;
  endfunction

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [DMW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PARAM_LOW) tol_low = value[24:0];
    else if (idx == CFG_PARAM_HIGH) tol_high = value[24:0];
    else if (idx == CFG_DET_MIN) det_thresh = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    pending_pairs.push_back(make_pair(0,0,0, 0,0,0, 0,0,0, 0,0,0));
    pending_pairs.push_back(make_pair(mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx));
    pending_pairs.push_back(make_pair(mn,mn,mn, mn,mn,mn, mn,mn,mn, mn,mn,mn));
    pending_pairs.push_back(make_pair(mx,mx,mx, mn,mn,mn, mn,mx,mn, mx,mn,mx));
    pending_pairs.push_back(make_pair(mn,0,0, mx,0,0, 0,mn,4096, 0,mx,4096));
    pending_pairs.push_back(make_pair(mn,0,mx, mx,0,mn, 0,mn,mn, 0,mx,mx));
    // Perpendicular skew pair, closest near the middle of both segments.
    pending_pairs.push_back(make_pair(-4096,0,0, 4096,0,0, 100,-4096,4096, 100,4096,4096));
    // Closest points exactly at the start of A and at the end of B.
    pending_pairs.push_back(make_pair(0,0,0, 4096,0,0, 0,-4096,8, 0,0,8));
    // Parallel and collinear segments fall into the degenerate branch.
    pending_pairs.push_back(make_pair(0,0,0, 8192,0,0, 0,4096,0, 8192,4096,0));
    pending_pairs.push_back(make_pair(0,0,0, 8192,0,0, 4096,0,0, 12288,0,0));
    // Zero-length segments.
    pending_pairs.push_back(make_pair(1,2,3, 1,2,3, -5,7,9, 20,-3,1));
    pending_pairs.push_back(make_pair(1,2,3, 9,-2,30, 5,5,5, 5,5,5));
    // Nearly parallel: tiny determinant against the threshold.
    pending_pairs.push_back(make_pair(0,0,0, 4096,0,0, 0,1,1, 4096,2,1));
    // Closest points beyond the segment ends: of A, then of both segments.
    pending_pairs.push_back(make_pair(0,0,0, 100,0,0, 5000,-100,50, 5000,100,50));
    pending_pairs.push_back(make_pair(-mx,mx,0, -mx+16,mx,0, mx,-mx,7, mx,-mx+16,7));
  endtask

  task automatic run_phase(int count, bit directed);
    if (directed) push_directed();
    for (int i = 0; i < count / 2; i++) pending_pairs.push_back(random_pair());
    // The sender holds off until every pending result has come back.
    wait_idle();
    for (int i = count / 2; i < count; i++) pending_pairs.push_back(random_pair());
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (45) @(negedge clk);

    no_idle = 1'b1;
    run_phase(80, 1'b1);
    no_idle = 1'b0;
    run_phase(220, 1'b0);

    write_reg(CFG_PARAM_LOW, 32'd0);
    write_reg(CFG_PARAM_HIGH, 32'd16777216);
    write_reg(CFG_DET_MIN, 32'd0);
    run_phase(150, 1'b1);

    write_reg(CFG_PARAM_HIGH, 32'h01FF_FFFF);
    write_reg(CFG_DET_MIN, 32'hFFFF_FFFF);
    run_phase(150, 1'b1);

    // Low tolerance above high rejects everything; index 3 is ignored.
    write_reg(CFG_PARAM_LOW, 32'd16777216);
    write_reg(CFG_PARAM_HIGH, 32'd0);
    write_reg(2'd3, 32'h1234_5678);
    run_phase(50, 1'b0);

    write_reg(CFG_PARAM_LOW, 32'd1000);
    write_reg(CFG_PARAM_HIGH, 32'd16000000);
    write_reg(CFG_DET_MIN, 32'd1 << 20);
    run_phase(200, 1'b0);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
